// ===== rtl/gf2mm_pkg.sv =====
// gf2mm_pkg: shared types and constants for the GF(2) matrix multiplier.
// Used by gf2mm_csr, gf2mm_cell and gf2_matrix_multiply; depends on nothing.
`default_nettype none

package gf2mm_pkg;

   localparam int MAX_INNER_DEFAULT = 64;
   localparam int MAX_COLS_DEFAULT  = 64;

   localparam int ROW_INDEX_WIDTH = 6;
   localparam int ROW_BITS_WIDTH  = 64;
   localparam int SIZE_WIDTH      = 7;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [SIZE_WIDTH-1:0] INNER_SIZE_RESET = 7'd8;
   localparam logic [SIZE_WIDTH-1:0] OUT_COLS_RESET   = 7'd8;

   typedef enum logic {
      ACTION_LOAD     = 1'b0,
      ACTION_MULTIPLY = 1'b1
   } action_type;

   typedef enum logic {
      REG_INNER_SIZE = 1'b0,
      REG_OUT_COLS   = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic                       valid;
      action_type                 action;
      logic [ROW_INDEX_WIDTH-1:0] index;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/gf2mm_csr.sv =====
// gf2mm_csr: APB-style register file holding inner_size and out_cols.
// Depends on gf2mm_pkg.
`default_nettype none

module gf2mm_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [gf2mm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [gf2mm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic      [gf2mm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                        pready,
   output logic      [gf2mm_pkg::SIZE_WIDTH-1:0]       inner_size,
   output logic      [gf2mm_pkg::SIZE_WIDTH-1:0]       out_cols
);

   logic [gf2mm_pkg::SIZE_WIDTH-1:0] inner_size_ff, inner_size_in;
   logic [gf2mm_pkg::SIZE_WIDTH-1:0] out_cols_ff, out_cols_in;
   gf2mm_pkg::csr_reg_type           reg_sel;
   logic                             wr_en;

   assign pready  = 1'b1;
   assign reg_sel = gf2mm_pkg::csr_reg_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      inner_size_in = inner_size_ff;
      out_cols_in   = out_cols_ff;
      prdata        = '0;
      unique case (reg_sel)
         gf2mm_pkg::REG_INNER_SIZE: begin
            prdata[gf2mm_pkg::SIZE_WIDTH-1:0] = inner_size_ff;
            if (wr_en) begin
               inner_size_in = pwdata[gf2mm_pkg::SIZE_WIDTH-1:0];
            end
         end
         gf2mm_pkg::REG_OUT_COLS: begin
            prdata[gf2mm_pkg::SIZE_WIDTH-1:0] = out_cols_ff;
            if (wr_en) begin
               out_cols_in = pwdata[gf2mm_pkg::SIZE_WIDTH-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_size_ff <= gf2mm_pkg::INNER_SIZE_RESET;
         out_cols_ff   <= gf2mm_pkg::OUT_COLS_RESET;
      end else begin
         inner_size_ff <= inner_size_in;
         out_cols_ff   <= out_cols_in;
      end
   end

   assign inner_size = inner_size_ff;
   assign out_cols   = out_cols_ff;

endmodule

`default_nettype wire

// ===== rtl/gf2mm_cell.sv =====
// gf2mm_cell: one chain cell; holds B row CELL_INDEX, loads it or folds it
// into a passing product row. Depends on gf2mm_pkg.
`default_nettype none

module gf2mm_cell #(
   parameter int MAX_INNER  = gf2mm_pkg::MAX_INNER_DEFAULT,
   parameter int MAX_COLS   = gf2mm_pkg::MAX_COLS_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire gf2mm_pkg::ctrl_type   ctrl_prev,
   input  wire logic [MAX_INNER-1:0]  abits_prev,
   input  wire logic [MAX_COLS-1:0]   data_prev,
   output gf2mm_pkg::ctrl_type        ctrl_next,
   output logic      [MAX_INNER-1:0]  abits_next,
   output logic      [MAX_COLS-1:0]   data_next
);

   gf2mm_pkg::ctrl_type   ctrl_ff;
   logic [MAX_INNER-1:0]  abits_ff;
   logic [MAX_COLS-1:0]   data_ff, data_in;
   logic [MAX_COLS-1:0]   row_ff;
   logic                  row_we;

   // loads travel with the stream, so later items see the new row
   assign row_we = advance && ctrl_prev.valid
                   && (ctrl_prev.action == gf2mm_pkg::ACTION_LOAD)
                   && (ctrl_prev.index == gf2mm_pkg::ROW_INDEX_WIDTH'(CELL_INDEX));

   always_comb begin
      data_in = data_prev;
      if (ctrl_prev.action == gf2mm_pkg::ACTION_MULTIPLY && abits_prev[CELL_INDEX]) begin
         data_in = data_prev ^ row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctrl_ff.valid <= ctrl_prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff.action <= ctrl_prev.action;
         ctrl_ff.index  <= ctrl_prev.index;
         abits_ff       <= abits_prev;
         data_ff        <= data_in;
      end
      if (row_we) begin
         row_ff <= data_prev;
      end
   end

   assign ctrl_next  = ctrl_ff;
   assign abits_next = abits_ff;
   assign data_next  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/gf2_matrix_multiply.sv =====
// Throughput: one item per cycle; each of the MAX_INNER chain cells handles
// one item per cycle and the chain stalls only while a product waits at the
// output and another product sits in the last cell.
// Reset: synchronous; clears the item valids and sets inner_size and
// out_cols to 8. Stored B rows are not cleared.
// Top level; depends on gf2mm_pkg, gf2mm_csr and gf2mm_cell.
`default_nettype none

module gf2_matrix_multiply #(
   parameter int MAX_INNER = gf2mm_pkg::MAX_INNER_DEFAULT,
   parameter int MAX_COLS  = gf2mm_pkg::MAX_COLS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_action,
   input  wire logic [gf2mm_pkg::ROW_INDEX_WIDTH-1:0]  req_row_index,
   input  wire logic [gf2mm_pkg::ROW_BITS_WIDTH-1:0]   req_row_bits,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic      [gf2mm_pkg::ROW_BITS_WIDTH-1:0]   rsp_product_row,
   output logic      [gf2mm_pkg::ROW_INDEX_WIDTH-1:0]  rsp_product_row_index,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [gf2mm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [gf2mm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic      [gf2mm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                        pready
);

   logic [gf2mm_pkg::SIZE_WIDTH-1:0] inner_size;
   logic [gf2mm_pkg::SIZE_WIDTH-1:0] out_cols;

   gf2mm_pkg::ctrl_type   ctrl_w  [MAX_INNER+1];
   logic [MAX_INNER-1:0]  abits_w [MAX_INNER+1];
   logic [MAX_COLS-1:0]   data_w  [MAX_INNER+1];

   logic [MAX_INNER-1:0]  inner_mask;
   logic [MAX_COLS-1:0]   col_mask;
   logic [gf2mm_pkg::ROW_BITS_WIDTH-1:0] col_mask_wide;
   logic                  advance;
   logic                  tail_mul;
   logic                  out_load;

   logic                                        rsp_valid_ff, rsp_valid_in;
   logic [gf2mm_pkg::ROW_BITS_WIDTH-1:0]        rsp_row_ff, rsp_row_in;
   logic [gf2mm_pkg::ROW_INDEX_WIDTH-1:0]       rsp_index_ff, rsp_index_in;

   gf2mm_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .inner_size (inner_size),
      .out_cols   (out_cols)
   );

   always_comb begin
      for (int k = 0; k < MAX_INNER; k++) begin
         inner_mask[k] = (gf2mm_pkg::SIZE_WIDTH'(k) < inner_size);
      end
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = (gf2mm_pkg::SIZE_WIDTH'(j) < out_cols);
      end
      col_mask_wide = '0;
      col_mask_wide[MAX_COLS-1:0] = col_mask;
   end

   // head of the chain: loads carry their row, products start from zero
   assign ctrl_w[0].valid  = req_valid;
   assign ctrl_w[0].action = gf2mm_pkg::action_type'(req_action);
   assign ctrl_w[0].index  = req_row_index;
   assign abits_w[0]       = req_row_bits[MAX_INNER-1:0] & inner_mask;
   assign data_w[0]        = (req_action == gf2mm_pkg::ACTION_MULTIPLY) ? '0
                             : req_row_bits[MAX_COLS-1:0];

   for (genvar k = 0; k < MAX_INNER; k++) begin : g_cell
      gf2mm_cell #(
         .MAX_INNER  (MAX_INNER),
         .MAX_COLS   (MAX_COLS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .ctrl_prev  (ctrl_w[k]),
         .abits_prev (abits_w[k]),
         .data_prev  (data_w[k]),
         .ctrl_next  (ctrl_w[k+1]),
         .abits_next (abits_w[k+1]),
         .data_next  (data_w[k+1])
      );
   end

   assign tail_mul  = ctrl_w[MAX_INNER].valid
                      && (ctrl_w[MAX_INNER].action == gf2mm_pkg::ACTION_MULTIPLY);
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign advance   = out_load || !tail_mul;
   assign req_ready = advance;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_index_in = rsp_index_ff;
      if (out_load) begin
         rsp_valid_in = tail_mul;
         rsp_row_in   = '0;
         rsp_row_in[MAX_COLS-1:0] = data_w[MAX_INNER] & col_mask;
         rsp_index_in = ctrl_w[MAX_INNER].index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_product_row       = rsp_row_ff;
   assign rsp_product_row_index = rsp_index_ff;

   a_stall_only_on_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && tail_mul) |-> !req_ready)
      else $error("chain advanced over a waiting product");

   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with free output");

   a_product_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_product_row & ~col_mask_wide) == '0))
      else $error("product bits beyond out_cols");

   a_product_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_product_row_index)))
      else $error("waiting product lost");

endmodule

`default_nettype wire
